// File: design/color_bar_pattern_nv12_top_assert.svh
// assertion macros for the color bar pattern generator
`ifndef COLOR_BAR_PATTERN_NV12_TOP_ASSERT_SVH
`define COLOR_BAR_PATTERN_NV12_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cbp_pkg.sv
// shared constants, types and color math for the color bar pattern generator
`default_nettype none

package cbp_pkg;

   // frame geometry
   localparam int MAX_DIMENSION = 4096;
   localparam int MIN_DIMENSION = 8;
   localparam int DIM_W         = 13;
   localparam int POS_W         = $clog2(MAX_DIMENSION);
   localparam int BAR_W_W       = POS_W - 2;
   localparam int BAR_POS_W     = POS_W - 3;
   localparam int MARKER_ROWS   = 4;
   localparam int MOD_CNT_W     = $clog2(DIM_W + 1);

   // reset frame size
   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

   // register map
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // bar colors, white through black
   localparam logic [7:0] LEVEL_WHITE = 8'd235;
   localparam logic [7:0] BAR_RED   [8] = '{8'd235, 8'd235, 8'd54,  8'd54,
                                            8'd235, 8'd235, 8'd54,  8'd16};
   localparam logic [7:0] BAR_GREEN [8] = '{8'd235, 8'd235, 8'd235, 8'd235,
                                            8'd54,  8'd54,  8'd54,  8'd16};
   localparam logic [7:0] BAR_BLUE  [8] = '{8'd235, 8'd54,  8'd235, 8'd54,
                                            8'd235, 8'd54,  8'd235, 8'd16};

   // bt.601 coefficients
   localparam logic [7:0] Y_R = 8'd66;
   localparam logic [7:0] Y_G = 8'd129;
   localparam logic [7:0] Y_B = 8'd25;
   localparam logic [7:0] Y_OFFSET = 8'd16;
   localparam logic signed [8:0] U_R = -9'sd38;
   localparam logic signed [8:0] U_G = -9'sd74;
   localparam logic signed [8:0] U_B = 9'sd112;
   localparam logic signed [8:0] V_R = 9'sd112;
   localparam logic signed [8:0] V_G = -9'sd94;
   localparam logic signed [8:0] V_B = -9'sd18;
   localparam logic [7:0] C_OFFSET = 8'd128;

   // keep a programmed size inside the supported range
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(MIN_DIMENSION)) begin
         r = DIM_W'(MIN_DIMENSION);
      end else if (v > DIM_W'(MAX_DIMENSION)) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // luma, rounded and wrapped to 8 bits
   function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [17:0] sum;
      sum = 18'(Y_R) * 18'(r) + 18'(Y_G) * 18'(g) + 18'(Y_B) * 18'(b) + 18'd128;
      return sum[15:8] + Y_OFFSET;
   endfunction

   // chroma, quotient by 256 truncated toward zero, wrapped to 8 bits
   function automatic logic [7:0] chroma_of(input logic signed [8:0] cr,
                                            input logic signed [8:0] cg,
                                            input logic signed [8:0] cb,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
      logic signed [18:0] rs;
      logic signed [18:0] gs;
      logic signed [18:0] bs;
      logic signed [18:0] sum;
      logic signed [18:0] adj;
      logic signed [18:0] quo;
      rs  = 19'(r);
      gs  = 19'(g);
      bs  = 19'(b);
      sum = cr * rs + cg * gs + cb * bs + 19'sd128;
      // bias negative sums so the shift rounds toward zero
      adj = (sum < 19'sd0) ? sum + 19'sd255 : sum;
      quo = adj >>> 8;
      return quo[7:0] + C_OFFSET;
   endfunction

endpackage

`default_nettype wire

// File: design/cbp_req_if.sv
// request channel: one pixel request per handshake
`default_nettype none

interface cbp_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// File: design/cbp_rsp_if.sv
// response channel: one yuv pixel per handshake
`default_nettype none

interface cbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma;
   logic [7:0] blue_diff;
   logic [7:0] red_diff;
   logic       chroma_valid;
   logic       end_of_line;
   logic       end_of_frame;

   modport source (output valid, output luma, output blue_diff, output red_diff,
                   output chroma_valid, output end_of_line, output end_of_frame,
                   input ready);
   modport sink   (input valid, input luma, input blue_diff, input red_diff,
                   input chroma_valid, input end_of_line, input end_of_frame,
                   output ready);
endinterface

`default_nettype wire

// File: design/cbp_csr_if.sv
// register write channel
`default_nettype none

interface cbp_csr_if;
   import cbp_pkg::*;

   logic             valid;
   logic             ready;
   csr_index_type    index;
   logic [DIM_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/color_bar_pattern_nv12_top.sv
// color bar test pattern generator with bt.601 yuv output
//
//   channel   dir   handshake       payload
//   req_if    in    valid/ready     restart
//   rsp_if    out   valid/ready     luma, blue_diff, red_diff, chroma_valid,
//                                   end_of_line, end_of_frame
//   csr_if    in    valid/ready     index, data (frame_width, frame_height)
//
// one pixel per cycle, on rsp_if the cycle after its request; a request enters
// only while the response register is empty or its pixel leaves in that cycle.
// a frame_height write starts a restoring modulo unit that re-derives
// the next marker row; req_if.ready stays low while it runs.
// reset is synchronous: position and marker go to zero, size to 640 x 480.
// a stall on rsp_if holds the response and lowers req_if.ready.
`default_nettype none

module color_bar_pattern_nv12_top (
   input wire logic  clock,
   input wire logic  reset,
   cbp_req_if.sink   req_if,
   cbp_rsp_if.source rsp_if,
   cbp_csr_if.sink   csr_if
);
   import cbp_pkg::*;

   `include "color_bar_pattern_nv12_top_assert.svh"

   // configuration registers
   logic [DIM_W-1:0]     frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]     frame_height_ff, frame_height_in;
   // raster position
   logic [POS_W-1:0]     column_ff, column_in;
   logic [POS_W-1:0]     row_ff, row_in;
   logic [2:0]           bar_index_ff, bar_index_in;
   logic [BAR_POS_W-1:0] bar_pos_ff, bar_pos_in;
   logic [POS_W-1:0]     marker_row_ff, marker_row_in;
   logic [POS_W-1:0]     next_marker_ff, next_marker_in;
   // modulo unit
   logic                 mod_busy_ff, mod_busy_in;
   logic [MOD_CNT_W-1:0] mod_count_ff, mod_count_in;
   logic [DIM_W-1:0]     mod_dividend_ff, mod_dividend_in;
   logic [DIM_W-1:0]     mod_rem_ff, mod_rem_in;
   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           luma_ff, blue_diff_ff, red_diff_ff;
   logic                 chroma_valid_ff, eol_ff, eof_ff;

   logic                 req_fire;
   logic                 csr_fire;
   logic [DIM_W-1:0]     w_use, h_use;
   logic [BAR_W_W-1:0]   bar_w;
   logic [POS_W-1:0]     col_e, row_e, marker_e, next_e;
   logic [2:0]           bar_e;
   logic [BAR_POS_W-1:0] pos_e;
   logic                 marker_hit;
   logic [7:0]           red, green, blue;
   logic                 cvalid, eol, eof, bar_done;
   logic [DIM_W-1:0]     next_sum, next_wrap;
   logic [DIM_W:0]       mod_trial, mod_sub;

   // handshakes
   assign req_if.ready = !mod_busy_ff && (!rsp_valid_ff || rsp_if.ready);
   assign csr_if.ready = 1'b1;
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_fire     = csr_if.valid && csr_if.ready;

   // size in use and bar width
   assign w_use = clamp_dim(frame_width_ff);
   assign h_use = clamp_dim(frame_height_ff);
   assign bar_w = w_use[DIM_W-1:3];

   // position after an optional restart
   assign col_e    = req_if.restart ? '0 : column_ff;
   assign row_e    = req_if.restart ? '0 : row_ff;
   assign bar_e    = req_if.restart ? '0 : bar_index_ff;
   assign pos_e    = req_if.restart ? '0 : bar_pos_ff;
   assign marker_e = req_if.restart ? '0 : marker_row_ff;
   assign next_e   = req_if.restart ? POS_W'(MARKER_ROWS) : next_marker_ff;

   // pixel color, marker rows forced to white
   assign marker_hit = (row_e >= marker_e) &&
                       (DIM_W'(row_e) < DIM_W'(marker_e) + DIM_W'(MARKER_ROWS));
   assign red   = marker_hit ? LEVEL_WHITE : BAR_RED[bar_e];
   assign green = marker_hit ? LEVEL_WHITE : BAR_GREEN[bar_e];
   assign blue  = marker_hit ? LEVEL_WHITE : BAR_BLUE[bar_e];

   // line and frame ends
   assign cvalid = !row_e[0] && !col_e[0];
   assign eol    = (DIM_W'(col_e) + DIM_W'(1)) >= w_use;
   assign eof    = eol && ((DIM_W'(row_e) + DIM_W'(1)) >= h_use);
   assign bar_done = (BAR_W_W'(pos_e) + BAR_W_W'(1)) >= bar_w;

   // marker row after the following frame, one subtract since next_e < height
   assign next_sum  = DIM_W'(next_e) + DIM_W'(MARKER_ROWS);
   assign next_wrap = (next_sum >= h_use) ? next_sum - h_use : next_sum;

   // restoring modulo step
   assign mod_trial = {mod_rem_ff, mod_dividend_ff[DIM_W-1]};
   assign mod_sub   = (mod_trial >= (DIM_W+1)'(h_use)) ?
                      mod_trial - (DIM_W+1)'(h_use) : mod_trial;

   // configuration writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_fire) begin
         unique case (csr_if.index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_if.data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_if.data;
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   // raster counters and marker update
   always_comb begin
      column_in      = column_ff;
      row_in         = row_ff;
      bar_index_in   = bar_index_ff;
      bar_pos_in     = bar_pos_ff;
      marker_row_in  = marker_row_ff;
      next_marker_in = next_marker_ff;
      if (req_fire) begin
         row_in         = row_e;
         marker_row_in  = marker_e;
         next_marker_in = next_e;
         if (eol) begin
            column_in    = '0;
            bar_index_in = '0;
            bar_pos_in   = '0;
            if (eof) begin
               row_in         = '0;
               marker_row_in  = next_e;
               next_marker_in = next_wrap[POS_W-1:0];
            end else begin
               row_in = row_e + POS_W'(1);
            end
         end else begin
            column_in    = col_e + POS_W'(1);
            bar_index_in = bar_e;
            bar_pos_in   = pos_e;
            if (bar_e != 3'd7) begin
               if (bar_done) begin
                  bar_index_in = bar_e + 3'd1;
                  bar_pos_in   = '0;
               end else begin
                  bar_pos_in = pos_e + BAR_POS_W'(1);
               end
            end
         end
      end else if (mod_busy_ff && (mod_count_ff == MOD_CNT_W'(1))) begin
         next_marker_in = mod_sub[POS_W-1:0];
      end
   end

   // modulo unit: (marker_row + 4) mod height after a height write
   always_comb begin
      mod_busy_in     = mod_busy_ff;
      mod_count_in    = mod_count_ff;
      mod_dividend_in = mod_dividend_ff;
      mod_rem_in      = mod_rem_ff;
      if (csr_fire && (csr_if.index == CSR_FRAME_HEIGHT)) begin
         mod_busy_in     = 1'b1;
         mod_count_in    = MOD_CNT_W'(DIM_W);
         mod_dividend_in = DIM_W'(marker_row_ff) + DIM_W'(MARKER_ROWS);
         mod_rem_in      = '0;
      end else if (mod_busy_ff) begin
         mod_count_in    = mod_count_ff - MOD_CNT_W'(1);
         mod_dividend_in = {mod_dividend_ff[DIM_W-2:0], 1'b0};
         mod_rem_in      = mod_sub[DIM_W-1:0];
         if (mod_count_ff == MOD_CNT_W'(1)) begin
            mod_busy_in = 1'b0;
         end
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_WIDTH;
         frame_height_ff <= RESET_HEIGHT;
         column_ff       <= '0;
         row_ff          <= '0;
         bar_index_ff    <= '0;
         bar_pos_ff      <= '0;
         marker_row_ff   <= '0;
         next_marker_ff  <= POS_W'(MARKER_ROWS);
         mod_busy_ff     <= 1'b0;
         mod_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
         bar_index_ff    <= bar_index_in;
         bar_pos_ff      <= bar_pos_in;
         marker_row_ff   <= marker_row_in;
         next_marker_ff  <= next_marker_in;
         mod_busy_ff     <= mod_busy_in;
         mod_count_ff    <= mod_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // modulo datapath
   always_ff @(posedge clock) begin
      mod_dividend_ff <= mod_dividend_in;
      mod_rem_ff      <= mod_rem_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         luma_ff         <= luma_of(red, green, blue);
         blue_diff_ff    <= cvalid ? chroma_of(U_R, U_G, U_B, red, green, blue) : 8'd0;
         red_diff_ff     <= cvalid ? chroma_of(V_R, V_G, V_B, red, green, blue) : 8'd0;
         chroma_valid_ff <= cvalid;
         eol_ff          <= eol;
         eof_ff          <= eof;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.luma         = luma_ff;
   assign rsp_if.blue_diff    = blue_diff_ff;
   assign rsp_if.red_diff     = red_diff_ff;
   assign rsp_if.chroma_valid = chroma_valid_ff;
   assign rsp_if.end_of_line  = eol_ff;
   assign rsp_if.end_of_frame = eof_ff;

   // checks
   `CBP_ASSERT_NOW(a_no_request_while_mod, mod_busy_ff, !req_fire, "request taken during modulo")
   `CBP_ASSERT_NOW(a_next_marker_in_frame, !mod_busy_ff, DIM_W'(next_marker_ff) < h_use, "next marker row outside frame")
   `CBP_ASSERT_NOW(a_eof_implies_eol, rsp_valid_ff && eof_ff, eol_ff, "frame end without line end")
   `CBP_ASSERT_NEXT(a_restart_clears_marker, req_fire && req_if.restart, marker_row_ff == '0, "restart left marker row set")

endmodule

`default_nettype wire
